@@ rtl/core/sha256bs_pkg.sv @@
// Shared types, constants and bit functions for the SHA-256 byte stream hasher.
`default_nettype none
package sha256bs_pkg;

	typedef logic [31:0]       word_t;
	typedef logic [7:0][31:0]  hash_t;    // [0] is a, [7] is h
	typedef logic [15:0][31:0] window_t;  // [0] is the oldest schedule word

	localparam logic [7:0] PadMarker = 8'h80;
	localparam int unsigned LenStart = 56;

	localparam hash_t InitHash = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	// Round constant table, one entry per round
	function automatic word_t round_k(input logic [5:0] idx);
		word_t k;
		case (idx)
			6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/sha256bs_round.sv @@
// One SHA-256 round and one message schedule step, shared over all 64 rounds.
`default_nettype none
module sha256bs_round (
	input  wire sha256bs_pkg::hash_t   v,
	input  wire sha256bs_pkg::window_t w,
	input  wire sha256bs_pkg::word_t   k,
	output sha256bs_pkg::hash_t        v_next,
	output sha256bs_pkg::word_t        w_new
);
	import sha256bs_pkg::*;

	word_t big1, big0, ch, maj, t1, t2, sig0, sig1;

	// Compression round
	always_comb begin
		big1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
		ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
		t1   = v[7] + big1 + ch + k + w[0];
		big0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
		maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
		t2   = big0 + maj;
		v_next[7] = v[6];
		v_next[6] = v[5];
		v_next[5] = v[4];
		v_next[4] = v[3] + t1;
		v_next[3] = v[2];
		v_next[2] = v[1];
		v_next[1] = v[0];
		v_next[0] = t1 + t2;
	end

	// Schedule word sixteen steps ahead
	always_comb begin
		sig0  = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
		sig1  = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
		w_new = sig1 + w[9] + sig0 + w[0];
	end

endmodule
`default_nettype wire

@@ rtl/core/sha256_byte_stream_hasher.sv @@
// Top level of the SHA-256 byte stream hasher: byte gathering, padding and round sequencer.
// A byte item is taken while idle; the item that completes a block is followed by the load,
// 64 rounds on the shared round unit, and the fold into the chaining words.
// A message end adds a padded block, and a second one when the length spills over,
// then eight digest words go out, one per cycle when taken.
// Reset (arst_n low) loads the initial hash values and clears counts and the sequencer.
`default_nettype none
module sha256_byte_stream_hasher (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire  [7:0]           data_byte,
	input  wire                  byte_present,
	input  wire                  message_end,
	output logic                 out_valid,
	input  wire                  out_ready,
	output sha256bs_pkg::word_t  digest_word,
	output logic [2:0]           word_index,
	output logic                 last_word
);
	import sha256bs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_ROUND, S_FOLD, S_PAD, S_LEN, S_OUT
	} state_t;

	state_t      state_q;
	hash_t       h_q;
	hash_t       v_q;
	window_t     w_q;
	window_t     pad_blk;
	hash_t       v_next;
	word_t       w_new;
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [63:0] bits_q;
	logic [2:0]  idx_q;
	logic        end_q;
	logic        fin_q;
	logic        len_q;
	logic        in_acc;
	logic        out_acc;
	logic        len_here;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = (state_q == S_OUT);
	assign in_acc      = in_valid && in_ready;
	assign out_acc     = out_valid && out_ready;
	assign digest_word = h_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'd7);

	sha256bs_round u_round (
		.v      (v_q),
		.w      (w_q),
		.k      (round_k(rnd_q)),
		.v_next (v_next),
		.w_new  (w_new)
	);

	// Build the padded block: marker, zeros, and the length when it fits
	always_comb begin
		len_here = (state_q == S_LEN) || (fill_q < 6'(LenStart));
		pad_blk  = w_q;
		for (int p = 0; p < 64; p++) begin
			if (state_q == S_LEN || 6'(p) > fill_q) begin
				pad_blk[p / 4][8 * (3 - p % 4) +: 8] = 8'h00;
			end else if (6'(p) == fill_q) begin
				pad_blk[p / 4][8 * (3 - p % 4) +: 8] = PadMarker;
			end
			if (len_here && p >= LenStart) begin
				pad_blk[p / 4][8 * (3 - p % 4) +: 8] = bits_q[8 * (63 - p) +: 8];
			end
		end
	end

	// Sequencer, chaining words and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			h_q     <= InitHash;
			fill_q  <= '0;
			rnd_q   <= '0;
			bits_q  <= '0;
			idx_q   <= '0;
			end_q   <= 1'b0;
			fin_q   <= 1'b0;
			len_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						end_q <= message_end;
						fin_q <= 1'b0;
						rnd_q <= '0;
						if (byte_present) begin
							fill_q <= fill_q + 6'd1;
							bits_q <= bits_q + 64'd8;
						end
						if (byte_present && fill_q == 6'd63) begin
							state_q <= S_ROUND;
						end else if (message_end) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					end_q   <= 1'b0;
					fin_q   <= len_here;
					len_q   <= !len_here;
					fill_q  <= '0;
					rnd_q   <= '0;
					state_q <= S_ROUND;
				end
				S_LEN: begin
					len_q   <= 1'b0;
					fin_q   <= 1'b1;
					rnd_q   <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					if (fin_q) begin
						idx_q   <= '0;
						state_q <= S_OUT;
					end else if (len_q) begin
						state_q <= S_LEN;
					end else if (end_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_acc) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							h_q     <= InitHash;
							bits_q  <= '0;
							fill_q  <= '0;
							fin_q   <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Block window and working variables
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc && byte_present) begin
					w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= data_byte;
				end
				v_q <= h_q;
			end
			S_PAD, S_LEN: begin
				w_q <= pad_blk;
				v_q <= h_q;
			end
			S_ROUND: begin
				v_q <= v_next;
				w_q <= {w_new, w_q[15:1]};
			end
			default: begin
				v_q <= v_q;
			end
		endcase
	end

	// Digest words go out only while no item is taken
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !in_ready)
		else $error("digest output while accepting items");

	// Sixty-four rounds end in the fold step
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND && rnd_q == 6'd63) |=> (state_q == S_FOLD))
		else $error("round sequence did not end in fold");

	// The final digest word returns the block to accepting items
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_word) |=> (in_ready && fill_q == 6'd0 && bits_q == 64'd0))
		else $error("no restart after final digest word");

endmodule
`default_nettype wire
